// ===== sv/pgt_pkg.sv =====
// shared types, constants and helper functions of the plane grid tessellator
`default_nettype none

package pgt_pkg;

  localparam int CNT_W       = 4;   // row, column and segment counts
  localparam int CORNER_W    = 3;
  localparam int SEG_W       = 8;   // segment count registers
  localparam int AXIS_W      = 2;
  localparam int SIZE_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int VIDX_W      = 7;
  localparam int POS_W       = 16;
  localparam int UV_W        = 16;
  localparam int HV_W        = 2 * CNT_W;       // hc * vc
  localparam int NUM_W       = 11;              // unit coordinate numerator, signed
  localparam int PROD_W      = NUM_W + SIZE_W + 1;
  localparam int DVS_W       = HV_W + 1;        // 2 * hc * vc
  localparam int QUO_W       = 17;
  localparam int DVD_W       = DVS_W + QUO_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int UV_SHIFT    = 15;

  localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd5;

  typedef enum logic {
    KIND_VERTEX = 1'b0,
    KIND_INDEX  = 1'b1
  } kind_e;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HORIZ_SEGMENTS = 3'd0,
    CFG_VERT_SEGMENTS  = 3'd1,
    CFG_HORIZ_AXIS     = 3'd2,
    CFG_VERT_AXIS      = 3'd3,
    CFG_FLIP_WINDING   = 3'd4,
    CFG_SIZE_X         = 3'd5,
    CFG_SIZE_Y         = 3'd6,
    CFG_SIZE_Z         = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_NUM,
    B_MUL,
    B_LOAD,
    B_DIV,
    B_FIN
  } back_state_e;

  // configuration with the segment counts already clamped
  typedef struct packed {
    logic [CNT_W-1:0]  hc;
    logic [CNT_W-1:0]  vc;
    logic [AXIS_W-1:0] haxis;
    logic [AXIS_W-1:0] vaxis;
    logic              flip;
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } cfg_t;

  // one classified word from the front sequencer
  typedef struct packed {
    kind_e             kind;
    logic [CNT_W-1:0]  row;
    logic [CNT_W-1:0]  col;
    logic [VIDX_W-1:0] vidx;
    logic              last;
  } item_t;

  // corner of the cell: bit 0 adds a row, bit 1 adds a column
  function automatic logic [1:0] corner_sel(input logic flip,
                                            input logic [CORNER_W-1:0] corner);
    logic [1:0] k;
    k = 2'd0;
    if (!flip) begin
      case (corner)
        3'd1:    k = 2'd1;
        3'd2:    k = 2'd2;
        3'd3:    k = 2'd2;
        3'd4:    k = 2'd1;
        3'd5:    k = 2'd3;
        default: k = 2'd0;
      endcase
    end else begin
      case (corner)
        3'd1:    k = 2'd2;
        3'd2:    k = 2'd1;
        3'd3:    k = 2'd2;
        3'd4:    k = 2'd3;
        3'd5:    k = 2'd1;
        default: k = 2'd0;
      endcase
    end
    return k;
  endfunction

  // unit coordinate on axis a, times 2*hc*vc
  function automatic logic signed [NUM_W-1:0] axis_num(input axis_e a,
                                                       input cfg_t cfg,
                                                       input logic [CNT_W-1:0] row,
                                                       input logic [CNT_W-1:0] col,
                                                       input logic [HV_W-1:0] hv);
    logic signed [NUM_W-1:0] n;
    logic [HV_W-1:0]         cv;
    logic [HV_W-1:0]         rh;
    cv = HV_W'(col * cfg.vc);
    rh = HV_W'(row * cfg.hc);
    n  = (a == AXIS_Y) ? '0 : -$signed({3'b000, hv});
    if (cfg.haxis == a) n = n + $signed({2'b00, cv, 1'b0});
    if (cfg.vaxis == a) n = n + $signed({2'b00, rh, 1'b0});
    return n;
  endfunction

  // round-half-away magnitude back to signed q8.8 with saturation
  function automatic logic [POS_W-1:0] sat_pos(input logic [QUO_W-1:0] mag,
                                               input logic neg);
    logic [QUO_W-1:0] negm;
    logic [POS_W-1:0] r;
    negm = -mag;
    if (!neg) begin
      r = (mag > QUO_W'(32767)) ? 16'h7FFF : mag[POS_W-1:0];
    end else begin
      r = (mag > QUO_W'(32768)) ? 16'h8000 : negm[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pgt_ifs.sv =====
// valid/ready stream interfaces for the restart input and the mesh output
`default_nettype none

interface pgt_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface pgt_out_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [pgt_pkg::POS_W-1:0]   pos_x;
  logic signed [pgt_pkg::POS_W-1:0]   pos_y;
  logic signed [pgt_pkg::POS_W-1:0]   pos_z;
  logic        [pgt_pkg::VIDX_W-1:0]  vertex_index;
  logic        [pgt_pkg::UV_W-1:0]    tex_u;
  logic        [pgt_pkg::UV_W-1:0]    tex_v;
  logic                               last;

  modport source (output valid, output kind, output pos_x, output pos_y, output pos_z,
                  output vertex_index, output tex_u, output tex_v, output last,
                  input ready);
  modport sink (input valid, input kind, input pos_x, input pos_y, input pos_z,
                input vertex_index, input tex_u, input tex_v, input last,
                output ready);
endinterface

`default_nettype wire

// ===== sv/pgt_front.sv =====
// front sequencer: walks the vertex and index counters, one word per accepted input
`default_nettype none

module pgt_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pgt_pkg::cfg_t cfg_i,
  pgt_in_if.sink             in_i,
  input  wire logic          full_i,
  output logic               push_o,
  output pgt_pkg::item_t     item_o
);

  logic                               phase_q, phase_d;
  logic [pgt_pkg::CNT_W-1:0]          row_q, row_d;
  logic [pgt_pkg::CNT_W-1:0]          col_q, col_d;
  logic [pgt_pkg::CORNER_W-1:0]       corner_q, corner_d;

  logic                               ph;
  logic [pgt_pkg::CNT_W-1:0]          r, c;
  logic [pgt_pkg::CORNER_W-1:0]       k;
  logic                               stale;
  logic [1:0]                         sel;
  logic [pgt_pkg::CNT_W-1:0]          er, ec;
  logic [pgt_pkg::CNT_W:0]            rl;
  logic [8:0]                         vsum;
  logic [pgt_pkg::CNT_W:0]            r1, c1;
  logic [pgt_pkg::CORNER_W-1:0]       k1;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    ph = phase_q;
    r  = row_q;
    c  = col_q;
    k  = corner_q;
    if (in_i.restart) begin
      ph = 1'b0;
      r  = '0;
      c  = '0;
      k  = '0;
    end
    // counters left outside the mesh by a configuration change
    if (!ph) stale = (r > cfg_i.vc) || (c > cfg_i.hc);
    else     stale = (r >= cfg_i.vc) || (c >= cfg_i.hc) || (k > pgt_pkg::LAST_CORNER);
    if (stale) begin
      ph = 1'b0;
      r  = '0;
      c  = '0;
      k  = '0;
    end

    sel = pgt_pkg::corner_sel(cfg_i.flip, k);
    if (!ph) begin
      er          = r;
      ec          = c;
      item_o.kind = pgt_pkg::KIND_VERTEX;
      item_o.last = 1'b0;
    end else begin
      er          = r + {3'b000, sel[0]};
      ec          = c + {3'b000, sel[1]};
      item_o.kind = pgt_pkg::KIND_INDEX;
      item_o.last = (r == cfg_i.vc - 4'd1) && (c == cfg_i.hc - 4'd1) &&
                    (k == pgt_pkg::LAST_CORNER);
    end
    rl          = {1'b0, cfg_i.hc} + 5'd1;
    vsum        = 9'(er * rl) + {5'b00000, ec};
    item_o.row  = er;
    item_o.col  = ec;
    item_o.vidx = vsum[pgt_pkg::VIDX_W-1:0];

    // advance
    phase_d  = ph;
    row_d    = r;
    col_d    = c;
    corner_d = k;
    r1       = {1'b0, r} + 5'd1;
    c1       = {1'b0, c} + 5'd1;
    k1       = k + 3'd1;
    if (!ph) begin
      if (c1 > {1'b0, cfg_i.hc}) begin
        col_d = '0;
        if (r1 > {1'b0, cfg_i.vc}) begin
          row_d    = '0;
          phase_d  = 1'b1;
          corner_d = '0;
        end else begin
          row_d = r1[pgt_pkg::CNT_W-1:0];
        end
      end else begin
        col_d = c1[pgt_pkg::CNT_W-1:0];
      end
    end else begin
      if (k1 > pgt_pkg::LAST_CORNER) begin
        corner_d = '0;
        if (c1 >= {1'b0, cfg_i.hc}) begin
          col_d = '0;
          if (r1 >= {1'b0, cfg_i.vc}) begin
            phase_d = 1'b0;
            row_d   = '0;
          end else begin
            row_d = r1[pgt_pkg::CNT_W-1:0];
          end
        end else begin
          col_d = c1[pgt_pkg::CNT_W-1:0];
        end
      end else begin
        corner_d = k1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 1'b0;
      row_q    <= '0;
      col_q    <= '0;
      corner_q <= '0;
    end else if (push_o) begin
      phase_q  <= phase_d;
      row_q    <= row_d;
      col_q    <= col_d;
      corner_q <= corner_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pgt_queue.sv =====
// short word queue between the front sequencer and the arithmetic back end
`default_nettype none

module pgt_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pgt_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output pgt_pkg::item_t      item_o,
  output logic                empty_o
);

  pgt_pkg::item_t               mem_q [pgt_pkg::QUEUE_DEPTH];
  logic [pgt_pkg::QPTR_W-1:0]   wp_q, rp_q;
  logic [pgt_pkg::QPTR_W:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (pgt_pkg::QPTR_W + 1)'(pgt_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pgt_div.sv =====
// restoring divider, one quotient bit per step, quotient known to fit QUO_W bits
`default_nettype none

module pgt_div (
  input  wire logic                        clk_i,
  input  wire logic                        load_i,
  input  wire logic                        step_i,
  input  wire logic [pgt_pkg::DVD_W-1:0]   dividend_i,
  input  wire logic [pgt_pkg::DVS_W-1:0]   divisor_i,
  output logic      [pgt_pkg::QUO_W-1:0]   quo_o
);

  logic [pgt_pkg::DVS_W-1:0] rem_q;
  logic [pgt_pkg::QUO_W-1:0] sh_q;
  logic [pgt_pkg::DVS_W:0]   trial;
  logic [pgt_pkg::DVS_W:0]   diff;
  logic                      ge;

  assign trial = {rem_q, sh_q[pgt_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};
  assign quo_o = sh_q;

  // quotient bits shift in where the dividend bits leave
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= dividend_i[pgt_pkg::DVD_W-1 -: pgt_pkg::DVS_W];
      sh_q  <= dividend_i[pgt_pkg::QUO_W-1:0];
    end else if (step_i) begin
      rem_q <= ge ? diff[pgt_pkg::DVS_W-1:0] : trial[pgt_pkg::DVS_W-1:0];
      sh_q  <= {sh_q[pgt_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== sv/pgt_back.sv =====
// arithmetic back end: positions and uv through scaling and shared-pace dividers
`default_nettype none

module pgt_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire pgt_pkg::cfg_t  cfg_i,
  input  wire pgt_pkg::item_t item_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  pgt_out_if.source           out_o
);

  localparam logic [4:0] LAST_STEP = 5'(pgt_pkg::QUO_W - 1);

  pgt_pkg::back_state_e state_q, state_d;

  pgt_pkg::item_t                     it_q;
  logic [pgt_pkg::HV_W-1:0]           hv_q;
  logic [pgt_pkg::DVS_W-1:0]          den_q;
  logic signed [pgt_pkg::NUM_W-1:0]   numx_q, numy_q, numz_q;
  logic signed [pgt_pkg::PROD_W-1:0]  prodx_q, prody_q, prodz_q;
  logic [4:0]                         cnt_q;

  logic                               load_div, step_div, out_load;
  logic [pgt_pkg::HV_W-1:0]           hv;
  logic [pgt_pkg::DVD_W-1:0]          dvd_x, dvd_y, dvd_z, dvd_u, dvd_v;
  logic [pgt_pkg::QUO_W-1:0]          quo_x, quo_y, quo_z, quo_u, quo_v;
  logic [pgt_pkg::CNT_W-1:0]          vrem;

  logic                               out_vld_q;
  logic                               kind_q, last_q;
  logic [pgt_pkg::POS_W-1:0]          posx_q, posy_q, posz_q;
  logic [pgt_pkg::VIDX_W-1:0]         vidx_q;
  logic [pgt_pkg::UV_W-1:0]           u_q, v_q;

  function automatic logic [pgt_pkg::DVD_W-1:0] round_dvd(
      input logic signed [pgt_pkg::PROD_W-1:0] p,
      input logic [pgt_pkg::HV_W-1:0] half);
    logic [pgt_pkg::PROD_W-1:0] mag;
    mag = p[pgt_pkg::PROD_W-1] ? -p : p;
    return mag[pgt_pkg::DVD_W-1:0] + pgt_pkg::DVD_W'(half);
  endfunction

  assign hv    = pgt_pkg::HV_W'(cfg_i.hc * cfg_i.vc);
  assign dvd_x = round_dvd(prodx_q, hv_q);
  assign dvd_y = round_dvd(prody_q, hv_q);
  assign dvd_z = round_dvd(prodz_q, hv_q);
  assign vrem  = cfg_i.vc - it_q.row;
  assign dvd_u = pgt_pkg::DVD_W'({it_q.col, {pgt_pkg::UV_SHIFT{1'b0}}}) +
                 pgt_pkg::DVD_W'(cfg_i.hc[pgt_pkg::CNT_W-1:1]);
  assign dvd_v = pgt_pkg::DVD_W'({vrem, {pgt_pkg::UV_SHIFT{1'b0}}}) +
                 pgt_pkg::DVD_W'(cfg_i.vc[pgt_pkg::CNT_W-1:1]);

  pgt_div u_div_x (.clk_i, .load_i(load_div), .step_i(step_div),
                   .dividend_i(dvd_x), .divisor_i(den_q), .quo_o(quo_x));
  pgt_div u_div_y (.clk_i, .load_i(load_div), .step_i(step_div),
                   .dividend_i(dvd_y), .divisor_i(den_q), .quo_o(quo_y));
  pgt_div u_div_z (.clk_i, .load_i(load_div), .step_i(step_div),
                   .dividend_i(dvd_z), .divisor_i(den_q), .quo_o(quo_z));
  pgt_div u_div_u (.clk_i, .load_i(load_div), .step_i(step_div),
                   .dividend_i(dvd_u), .divisor_i(pgt_pkg::DVS_W'(cfg_i.hc)),
                   .quo_o(quo_u));
  pgt_div u_div_v (.clk_i, .load_i(load_div), .step_i(step_div),
                   .dividend_i(dvd_v), .divisor_i(pgt_pkg::DVS_W'(cfg_i.vc)),
                   .quo_o(quo_v));

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_div = 1'b0;
    step_div = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      pgt_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = pgt_pkg::B_NUM;
        end
      end
      pgt_pkg::B_NUM:  state_d = pgt_pkg::B_MUL;
      pgt_pkg::B_MUL:  state_d = pgt_pkg::B_LOAD;
      pgt_pkg::B_LOAD: begin
        load_div = 1'b1;
        state_d  = pgt_pkg::B_DIV;
      end
      pgt_pkg::B_DIV: begin
        step_div = 1'b1;
        if (cnt_q == LAST_STEP) state_d = pgt_pkg::B_FIN;
      end
      pgt_pkg::B_FIN: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = pgt_pkg::B_IDLE;
        end
      end
      default: state_d = pgt_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pgt_pkg::B_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) it_q <= item_i;
    if (state_q == pgt_pkg::B_NUM) begin
      hv_q   <= hv;
      den_q  <= {hv, 1'b0};
      numx_q <= pgt_pkg::axis_num(pgt_pkg::AXIS_X, cfg_i, it_q.row, it_q.col, hv);
      numy_q <= pgt_pkg::axis_num(pgt_pkg::AXIS_Y, cfg_i, it_q.row, it_q.col, hv);
      numz_q <= pgt_pkg::axis_num(pgt_pkg::AXIS_Z, cfg_i, it_q.row, it_q.col, hv);
    end
    if (state_q == pgt_pkg::B_MUL) begin
      prodx_q <= numx_q * $signed({1'b0, cfg_i.size_x});
      prody_q <= numy_q * $signed({1'b0, cfg_i.size_y});
      prodz_q <= numz_q * $signed({1'b0, cfg_i.size_z});
    end
    if (load_div)      cnt_q <= '0;
    else if (step_div) cnt_q <= cnt_q + 5'd1;
    if (out_load) begin
      kind_q <= it_q.kind;
      last_q <= it_q.last;
      vidx_q <= it_q.vidx;
      u_q    <= quo_u[pgt_pkg::UV_W-1:0];
      v_q    <= quo_v[pgt_pkg::UV_W-1:0];
      if (it_q.kind == pgt_pkg::KIND_VERTEX) begin
        posx_q <= pgt_pkg::sat_pos(quo_x, prodx_q[pgt_pkg::PROD_W-1]);
        posy_q <= pgt_pkg::sat_pos(quo_y, prody_q[pgt_pkg::PROD_W-1]);
        posz_q <= pgt_pkg::sat_pos(quo_z, prodz_q[pgt_pkg::PROD_W-1]);
      end else begin
        posx_q <= '0;
        posy_q <= '0;
        posz_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)         out_vld_q <= 1'b0;
    else if (out_load)   out_vld_q <= 1'b1;
    else if (out_o.ready) out_vld_q <= 1'b0;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.kind         = kind_q;
  assign out_o.pos_x        = posx_q;
  assign out_o.pos_y        = posy_q;
  assign out_o.pos_z        = posz_q;
  assign out_o.vertex_index = vidx_q;
  assign out_o.tex_u        = u_q;
  assign out_o.tex_v        = v_q;
  assign out_o.last         = last_q;

endmodule

`default_nettype wire

// ===== sv/plane_grid_tessellator.sv =====
// plane grid tessellator: streams the vertices and triangle indices of a tessellated plane
//
// in_i carries one restart bit per word; each accepted word yields exactly one
// output word on out_o. restart = 1 begins again at vertex zero, 0 moves on to
// the next item: (vc+1)*(hc+1) vertex words row by row, then six index words
// per cell, after which the sequence wraps. hc and vc are the segment
// registers clamped to 1..MAX_SEGMENTS.
// The front sequencer takes a word into a 4-word queue whenever the queue has
// room. The back end handles one word at a time: operand setup, scaling
// multiply and a 17-step restoring division (position and uv dividers run
// side by side); it takes no new word until the last has reached the output
// register. When out_o stalls, a finished word waits in the output register,
// the next one waits in the back end, and the queue keeps taking input until
// it fills. Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is written one
// register per cycle; the user must write it only while the block is idle,
// which the block itself does not enforce. Reset empties the queue and output
// register, puts the sequence at vertex zero and loads the configuration defaults.
`default_nettype none

module plane_grid_tessellator #(
  parameter int MAX_SEGMENTS = 10
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [pgt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [pgt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  pgt_in_if.sink                                  in_i,
  pgt_out_if.source                               out_o
);

  logic [pgt_pkg::SEG_W-1:0]  hseg_q, vseg_q;
  logic [pgt_pkg::AXIS_W-1:0] haxis_q, vaxis_q;
  logic                       flip_q;
  logic [pgt_pkg::SIZE_W-1:0] size_x_q, size_y_q, size_z_q;

  pgt_pkg::cfg_t  cfg;
  pgt_pkg::item_t push_item, pop_item;
  logic           push, pop, full, empty;

  function automatic logic [pgt_pkg::CNT_W-1:0] clamp_seg(
      input logic [pgt_pkg::SEG_W-1:0] v);
    logic [pgt_pkg::CNT_W-1:0] r;
    if (v == '0)                                  r = pgt_pkg::CNT_W'(1);
    else if (v > pgt_pkg::SEG_W'(MAX_SEGMENTS))   r = pgt_pkg::CNT_W'(MAX_SEGMENTS);
    else                                          r = v[pgt_pkg::CNT_W-1:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hseg_q   <= 8'd1;
      vseg_q   <= 8'd1;
      haxis_q  <= pgt_pkg::AXIS_X;
      vaxis_q  <= pgt_pkg::AXIS_Z;
      flip_q   <= 1'b0;
      size_x_q <= 16'd256;
      size_y_q <= 16'd256;
      size_z_q <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (pgt_pkg::cfg_idx_e'(cfg_idx_i))
        pgt_pkg::CFG_HORIZ_SEGMENTS: hseg_q   <= cfg_data_i[pgt_pkg::SEG_W-1:0];
        pgt_pkg::CFG_VERT_SEGMENTS:  vseg_q   <= cfg_data_i[pgt_pkg::SEG_W-1:0];
        pgt_pkg::CFG_HORIZ_AXIS:     haxis_q  <= cfg_data_i[pgt_pkg::AXIS_W-1:0];
        pgt_pkg::CFG_VERT_AXIS:      vaxis_q  <= cfg_data_i[pgt_pkg::AXIS_W-1:0];
        pgt_pkg::CFG_FLIP_WINDING:   flip_q   <= cfg_data_i[0];
        pgt_pkg::CFG_SIZE_X:         size_x_q <= cfg_data_i;
        pgt_pkg::CFG_SIZE_Y:         size_y_q <= cfg_data_i;
        pgt_pkg::CFG_SIZE_Z:         size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.hc     = clamp_seg(hseg_q);
    cfg.vc     = clamp_seg(vseg_q);
    cfg.haxis  = haxis_q;
    cfg.vaxis  = vaxis_q;
    cfg.flip   = flip_q;
    cfg.size_x = size_x_q;
    cfg.size_y = size_y_q;
    cfg.size_z = size_z_q;
  end

  pgt_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i  (cfg),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  pgt_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  pgt_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i   (cfg),
    .item_i  (pop_item),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== test/plane_grid_mesh_checker.sv =====
// checker for the plane grid tessellator: predicts every mesh word and compares the output
`timescale 1ns / 1ps

module plane_grid_mesh_checker
  import pgt_pkg::*;
#(
  parameter int MAX_SEGS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pgt_in_if                     in_w,
  pgt_out_if                    out_w,
  output int                    errors_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef struct packed {
    kind_e             kind;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [VIDX_W-1:0] vertex_index;
    logic [UV_W-1:0]   tex_u;
    logic [UV_W-1:0]   tex_v;
    logic              last;
  } mesh_word_t;

  // corner sequence per cell, two bits per corner: bit 0 next row, bit 1 next column
  localparam logic [11:0] PLAIN_ORDER   = {2'd3, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0};
  localparam logic [11:0] FLIPPED_ORDER = {2'd1, 2'd3, 2'd2, 2'd1, 2'd2, 2'd0};

  // configuration copy
  logic [SEG_W-1:0]  h_segs, v_segs;
  logic [AXIS_W-1:0] h_axis, v_axis;
  logic              flip_wind;
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;

  // position of the walk through the mesh
  logic in_index_phase;
  int   row_n, col_n, corner_n;

  mesh_word_t expected_words[$];

  function automatic longint seg_clamp(input logic [SEG_W-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_SEGS) return MAX_SEGS;
    return v;
  endfunction

  function automatic void clear_walk();
    in_index_phase = 1'b0;
    row_n = 0;
    col_n = 0;
    corner_n = 0;
  endfunction

  // exact scaled coordinate, rounded half away from zero, saturated to q8.8
  function automatic logic [POS_W-1:0] scaled_coord(input axis_e a, input longint r,
                                                    input longint c, input longint hc,
                                                    input longint vc,
                                                    input logic [SIZE_W-1:0] scale);
    longint den, num, prod, q;
    den = 2 * hc * vc;
    num = (a == AXIS_Y) ? 0 : -(hc * vc);
    if (h_axis == a) num += 2 * c * vc;
    if (v_axis == a) num += 2 * r * hc;
    prod = num * longint'(scale);
    if (prod >= 0) q = (prod + den / 2) / den;
    else q = -((-prod + den / 2) / den);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[POS_W-1:0];
  endfunction

  function automatic logic [UV_W-1:0] uv_frac(input longint n, input longint d);
    longint q;
    q = (n * 32768 + d / 2) / d;
    return q[UV_W-1:0];
  endfunction

  function automatic mesh_word_t next_mesh_word(input logic restart);
    mesh_word_t w;
    longint     hc, vc, r, c;
    logic [1:0] k;
    logic       stale;
    hc = seg_clamp(h_segs);
    vc = seg_clamp(v_segs);
    if (restart) clear_walk();
    // a configuration change may leave the walk outside the mesh
    if (!in_index_phase) stale = (row_n > vc) || (col_n > hc);
    else stale = (row_n >= vc) || (col_n >= hc) || (corner_n > 5);
    if (stale) clear_walk();
    w = '0;
    if (!in_index_phase) begin
      r = row_n;
      c = col_n;
      w.kind  = KIND_VERTEX;
      w.pos_x = scaled_coord(AXIS_X, r, c, hc, vc, size_x_q);
      w.pos_y = scaled_coord(AXIS_Y, r, c, hc, vc, size_y_q);
      w.pos_z = scaled_coord(AXIS_Z, r, c, hc, vc, size_z_q);
    end else begin
      k = flip_wind ? FLIPPED_ORDER[corner_n*2 +: 2] : PLAIN_ORDER[corner_n*2 +: 2];
      r = row_n + k[0];
      c = col_n + k[1];
      w.kind = KIND_INDEX;
      w.last = (row_n == vc - 1) && (col_n == hc - 1) && (corner_n == 5);
    end
    w.vertex_index = VIDX_W'(c + r * (hc + 1));
    w.tex_u = uv_frac(c, hc);
    w.tex_v = uv_frac(vc - r, vc);

    if (!in_index_phase) begin
      col_n++;
      if (col_n > hc) begin
        col_n = 0;
        row_n++;
        if (row_n > vc) begin
          row_n = 0;
          in_index_phase = 1'b1;
          corner_n = 0;
        end
      end
    end else begin
      corner_n++;
      if (corner_n > 5) begin
        corner_n = 0;
        col_n++;
        if (col_n >= hc) begin
          col_n = 0;
          row_n++;
          if (row_n >= vc) clear_walk();
        end
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s expected %h got %h",
                                checked_o, name, want, got));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    mesh_word_t want;
    if (!rst_ni) begin
      h_segs    = 8'd1;
      v_segs    = 8'd1;
      h_axis    = AXIS_X;
      v_axis    = AXIS_Z;
      flip_wind = 1'b0;
      size_x_q  = 16'd256;
      size_y_q  = 16'd256;
      size_z_q  = 16'd256;
      clear_walk();
      expected_words.delete();
      errors_o  = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_HORIZ_SEGMENTS: h_segs    = cfg_data_i[SEG_W-1:0];
          CFG_VERT_SEGMENTS:  v_segs    = cfg_data_i[SEG_W-1:0];
          CFG_HORIZ_AXIS:     h_axis    = cfg_data_i[AXIS_W-1:0];
          CFG_VERT_AXIS:      v_axis    = cfg_data_i[AXIS_W-1:0];
          CFG_FLIP_WINDING:   flip_wind = cfg_data_i[0];
          CFG_SIZE_X:         size_x_q  = cfg_data_i;
          CFG_SIZE_Y:         size_y_q  = cfg_data_i;
          CFG_SIZE_Z:         size_z_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_w.valid && out_w.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing outstanding", checked_o));
        end else begin
          want = expected_words.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_w.kind));
          check_field("pos_x", want.pos_x, out_w.pos_x);
          check_field("pos_y", want.pos_y, out_w.pos_y);
          check_field("pos_z", want.pos_z, out_w.pos_z);
          check_field("vertex_index", 16'(want.vertex_index), 16'(out_w.vertex_index));
          check_field("tex_u", want.tex_u, out_w.tex_u);
          check_field("tex_v", want.tex_v, out_w.tex_v);
          check_field("last", 16'(want.last), 16'(out_w.last));
        end
        checked_o++;
      end
      if (in_w.valid && in_w.ready) expected_words.push_back(next_mesh_word(in_w.restart));
      pending_o = expected_words.size();
    end
  end

endmodule

// ===== test/plane_grid_tessellator_tb.sv =====
// top of the plane grid tessellator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module plane_grid_tessellator_tb;
  import pgt_pkg::*;

  localparam int MAX_SEGS      = 10;
  localparam int RANDOM_WORDS  = 500;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int WATCH_LIMIT   = 4000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  pgt_in_if  mesh_in ();
  pgt_out_if mesh_out ();

  int errors, pending, checked;
  int words_sent, words_out, hold_left, idle_cycles;
  bit held;
  logic [SEG_W-1:0] seg_h_req, seg_v_req;

  plane_grid_tessellator #(
    .MAX_SEGMENTS (MAX_SEGS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (mesh_in),
    .out_o      (mesh_out)
  );

  plane_grid_mesh_checker #(
    .MAX_SEGS (MAX_SEGS)
  ) mesh_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_w       (mesh_in),
    .out_w      (mesh_out),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    mesh_in.valid    = 1'b0;
    mesh_in.restart  = 1'b0;
    mesh_out.ready   = 1'b0;
    words_sent       = 0;
    words_out        = 0;
    hold_left        = 0;
    held             = 1'b0;
    idle_cycles      = 0;
    seg_h_req        = 8'd1;
    seg_v_req        = 8'd1;
  end

  // receiver: random stalls, a stall-free stretch, and one long hold-off
  always @(posedge clk) begin
    if (mesh_out.valid && mesh_out.ready) words_out++;
    if (hold_left > 0) begin
      hold_left--;
      mesh_out.ready <= 1'b0;
    end else if (words_out == 250 && !held) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
      mesh_out.ready <= 1'b0;
    end else begin
      mesh_out.ready <= (words_out >= 100 && words_out < 200) ||
                        ($urandom_range(0, 99) >= 11);
    end
  end

  always @(posedge clk) begin
    if ((mesh_in.valid && mesh_in.ready) || (mesh_out.valid && mesh_out.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCH_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx == CFG_HORIZ_SEGMENTS) seg_h_req = data[SEG_W-1:0];
    if (idx == CFG_VERT_SEGMENTS) seg_v_req = data[SEG_W-1:0];
    @(posedge clk);
  endtask

  task automatic send_word(input logic restart);
    cfg_we <= 1'b0;
    while (!(words_sent >= 100 && words_sent < 200) && $urandom_range(0, 99) < 11) begin
      mesh_in.valid <= 1'b0;
      @(posedge clk);
    end
    mesh_in.valid   <= 1'b1;
    mesh_in.restart <= restart;
    @(posedge clk);
    while (!mesh_in.ready) @(posedge clk);
    words_sent++;
  endtask

  // let every outstanding word drain before touching the registers
  task automatic settle();
    mesh_in.valid <= 1'b0;
    cfg_we        <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int hc, vc, phase_len, sel, settings;
    int random_words;
    logic [SEG_W-1:0] seg;
    logic [CFG_DATA_W-1:0] val;
    settings = 2;
    random_words = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // equal horizontal and vertical axes on x, full scale: x saturates
    write_reg(CFG_HORIZ_SEGMENTS, 16'h0003);
    write_reg(CFG_VERT_SEGMENTS, 16'h0001);
    write_reg(CFG_HORIZ_AXIS, 16'(AXIS_X));
    write_reg(CFG_VERT_AXIS, 16'(AXIS_X));
    write_reg(CFG_SIZE_X, 16'hFFFF);
    write_reg(CFG_SIZE_Z, 16'h0000);
    send_word(1'b1);
    repeat (13) send_word(1'b0);
    settle();

    // walk now sits past the shrunk mesh; column axis steps nothing, flipped winding
    write_reg(CFG_HORIZ_SEGMENTS, 16'hFF00);
    write_reg(CFG_FLIP_WINDING, 16'h0001);
    write_reg(CFG_HORIZ_AXIS, 16'(AXIS_NONE));
    write_reg(CFG_VERT_AXIS, 16'(AXIS_Z));
    write_reg(CFG_SIZE_Y, 16'hFFFF);
    write_reg(CFG_SIZE_Z, 16'hFFFF);
    repeat (11) send_word(1'b0);

    while (random_words < RANDOM_WORDS) begin
      settle();
      settings++;
      if (settings == 5) begin
        // largest mesh, enough words to reach the top vertex number
        write_reg(CFG_HORIZ_SEGMENTS, 16'(MAX_SEGS));
        write_reg(CFG_VERT_SEGMENTS, 16'(MAX_SEGS));
      end else begin
        for (int r = 0; r < 8; r++) begin
          if ($urandom_range(0, 9) < 7) begin
            case (cfg_idx_e'(r))
              CFG_HORIZ_SEGMENTS, CFG_VERT_SEGMENTS: begin
                sel = $urandom_range(0, 9);
                if (sel < 6) seg = 8'($urandom_range(0, 3));
                else if (sel < 8) seg = 8'($urandom_range(4, MAX_SEGS));
                else if (sel == 8) seg = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else seg = 8'($urandom_range(MAX_SEGS + 1, 254));
                val = {8'($urandom), seg};
              end
              CFG_HORIZ_AXIS, CFG_VERT_AXIS:
                val = {14'($urandom), 2'($urandom_range(0, 3))};
              CFG_FLIP_WINDING:
                val = {15'($urandom), 1'($urandom_range(0, 1))};
              default: begin
                sel = $urandom_range(0, 7);
                val = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom);
              end
            endcase
            write_reg(cfg_idx_e'(r), val);
          end
        end
      end
      hc = (seg_h_req == 0) ? 1 : (seg_h_req > MAX_SEGS) ? MAX_SEGS : seg_h_req;
      vc = (seg_v_req == 0) ? 1 : (seg_v_req > MAX_SEGS) ? MAX_SEGS : seg_v_req;
      phase_len = (hc + 1) * (vc + 1) + 6 * hc * vc + $urandom_range(0, 6);
      if (phase_len > 140) phase_len = 140;
      // mostly whole meshes from vertex zero, sometimes carrying on from the old walk
      send_word($urandom_range(0, 4) != 0);
      for (int n = 1; n < phase_len; n++) send_word($urandom_range(0, 99) < 3);
      random_words += phase_len;
    end

    settle();
    $display("run covered %0d input words over %0d mesh settings, %0d output words checked",
             words_sent, settings, checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
